### src/mlep_pkg.sv
// Package for the multi-list entry pool: item types, link and count widths,
// request and register codes, sequencer states. No dependencies.
package mlep_pkg;

    localparam int LINK_W  = 11;
    localparam int COUNT_W = 11;
    localparam int LIST_W  = 3;
    localparam int ENTRY_W = 10;
    localparam int MODE_W  = 2;
    localparam int RES_W   = 16;
    localparam int CFG_W   = 2;

    localparam logic [LINK_W-1:0] LINK_NULL     = 11'h7FF;
    localparam logic [RES_W-1:0]  RESERVE_RESET = 16'h12C;
    localparam logic [LIST_W-1:0] GENERAL_RESET = 3'd1;
    localparam logic [LIST_W-1:0] LIMITED_RESET = 3'd2;

    localparam logic [MODE_W-1:0] MODE_ALLOC_GEN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC_LIM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE      = 2'd2;

    localparam logic [CFG_W-1:0] CFG_GENERAL_LIST = 2'd0;
    localparam logic [CFG_W-1:0] CFG_LIMITED_LIST = 2'd1;
    localparam logic [CFG_W-1:0] CFG_RESERVE      = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ENTRY_W-1:0] entry;
        logic [LIST_W-1:0]  target_list;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [ENTRY_W-1:0] granted_entry;
        logic [COUNT_W-1:0] list_size;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LINK,
        ST_UNLINK,
        ST_DONE
    } t_state;

endpackage

### src/mlep_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlep_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/multi_list_entry_pool_core.sv
// Top level of the multi-list entry pool: sequencer, list heads and counts,
// link and back-link memories. Depends on mlep_pkg and mlep_ram.
//
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_ready, payload
//   i_in_item); every request gives exactly one result on the output channel
//   (o_out_valid / i_out_ready, payload o_out_item). Registers are written on
//   the plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata) while idle; the
//   block does not enforce this, the user must. One request is worked at a
//   time; o_in_ready is high only when the sequencer is idle. The link memory
//   holds each entry's forward link and owner list, the back-link memory its
//   backward link; each has one write port, and a full relink needs three
//   back-link writes. A relink steps through the read, link, unlink and done
//   states; a move to the entry's own list (or an allocation into the free
//   list) goes from read straight to done, a refused request from idle to
//   done. After reset a clearing pass threads all ENTRIES entries onto the
//   free list, one entry per cycle; no request is accepted during it,
//   register writes are. The result sits in an output register: a new
//   request may be accepted while it waits, and that request then holds in
//   its last step until the receiver takes the waiting result.
module multi_list_entry_pool_core
    import mlep_pkg::*;
#(
    parameter int ENTRIES = 1024,
    parameter int LISTS   = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_idx,
    input  logic [RES_W-1:0]   i_cfg_wdata
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [LINK_W-1:0]  ENTRY_LIM = LINK_W'(ENTRIES);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(ENTRIES - 1);
    localparam logic [LIST_W:0]    LIST_LIM  = (LIST_W + 1)'(LISTS);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(ENTRIES);

    t_state r_state, n_state;

    logic [LIST_W-1:0]  r_gen_list, r_lim_list;
    logic [RES_W-1:0]   r_reserve;
    logic [LINK_W-1:0]  r_head  [LISTS];
    logic [COUNT_W-1:0] r_count [LISTS];
    logic [AW-1:0]      r_clr;

    logic [LINK_W-1:0]  r_e, r_p, r_n, r_h;
    logic [LIST_W-1:0]  r_dst, r_src;
    logic               r_ok, r_moved;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [LIST_W-1:0]  in_dst, sel_dst;
    logic [COUNT_W-1:0] dst_cnt;
    logic [LINK_W-1:0]  dst_head;
    logic [RES_W-1:0]   lim_gap;
    logic               is_alloc, alloc_ok, move_ok, in_go, same_list;
    logic [LINK_W-1:0]  in_e;
    logic               load_out;

    logic                     nx_we, pv_we;
    logic [AW-1:0]            nx_waddr, pv_waddr;
    logic [LINK_W-1:0]        nx_wdata, pv_wdata, nx_rdata, pv_rdata;
    logic [LIST_W-1:0]        ow_wdata, ow_rdata;
    logic [LIST_W+LINK_W-1:0] lk_rdata;

    mlep_ram #(.WIDTH(LIST_W + LINK_W), .DEPTH(ENTRIES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata ({ow_wdata, nx_wdata}),
        .i_raddr (in_e[AW-1:0]),
        .o_rdata (lk_rdata)
    );

    mlep_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (in_e[AW-1:0]),
        .o_rdata (pv_rdata)
    );

    assign nx_rdata = lk_rdata[LINK_W-1:0];
    assign ow_rdata = lk_rdata[LINK_W +: LIST_W];

    always_comb begin
        case (i_in_item.mode)
            MODE_ALLOC_GEN: in_dst = r_gen_list;
            MODE_ALLOC_LIM: in_dst = r_lim_list;
            default:        in_dst = i_in_item.target_list;
        endcase
    end

    assign sel_dst = (r_state == ST_IDLE) ? in_dst : r_dst;

    always_comb begin
        dst_cnt  = '0;
        dst_head = LINK_NULL;
        for (int i = 0; i < LISTS; i++) begin
            if (LIST_W'(i) == sel_dst) begin
                dst_cnt  = r_count[i];
                dst_head = r_head[i];
            end
        end
    end

    assign is_alloc = (i_in_item.mode == MODE_ALLOC_GEN) ||
                      (i_in_item.mode == MODE_ALLOC_LIM);
    assign lim_gap  = r_reserve - RES_W'(dst_cnt);
    assign alloc_ok = ({1'b0, in_dst} < LIST_LIM) && (r_count[0] != '0) &&
                      (r_head[0] < ENTRY_LIM) &&
                      ((i_in_item.mode != MODE_ALLOC_LIM) ||
                       (lim_gap < RES_W'(r_count[0])));
    assign move_ok  = (LINK_W'(i_in_item.entry) < ENTRY_LIM) &&
                      ({1'b0, i_in_item.target_list} < LIST_LIM);
    assign in_go    = is_alloc ? alloc_ok :
                      ((i_in_item.mode == MODE_MOVE) && move_ok);
    assign in_e     = is_alloc ? r_head[0] : LINK_W'(i_in_item.entry);
    assign same_list = ({1'b0, ow_rdata} >= LIST_LIM) || (ow_rdata == r_dst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        nx_we      = 1'b0;
        pv_we      = 1'b0;
        nx_waddr   = r_e[AW-1:0];
        pv_waddr   = r_e[AW-1:0];
        nx_wdata   = r_h;
        pv_wdata   = LINK_NULL;
        ow_wdata   = r_dst;
        unique case (r_state)
            ST_CLEAR: begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_waddr = r_clr;
                pv_waddr = r_clr;
                nx_wdata = (r_clr == LAST_ADDR) ? LINK_NULL :
                           LINK_W'(r_clr) + LINK_W'(1);
                pv_wdata = (r_clr == '0) ? LINK_NULL :
                           LINK_W'(r_clr) - LINK_W'(1);
                ow_wdata = '0;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = in_go ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                n_state = same_list ? ST_DONE : ST_LINK;
            end
            ST_LINK: begin
                nx_we    = 1'b1;
                pv_we    = (r_h < ENTRY_LIM);
                pv_waddr = r_h[AW-1:0];
                pv_wdata = r_e;
                n_state  = ST_UNLINK;
            end
            ST_UNLINK: begin
                nx_we    = (r_p < ENTRY_LIM);
                nx_waddr = r_p[AW-1:0];
                nx_wdata = r_n;
                ow_wdata = r_src;
                pv_we    = (r_n < ENTRY_LIM);
                pv_waddr = r_n[AW-1:0];
                pv_wdata = r_p;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                pv_we = r_moved;
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_list <= GENERAL_RESET;
            r_lim_list <= LIMITED_RESET;
            r_reserve  <= RESERVE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GENERAL_LIST: r_gen_list <= i_cfg_wdata[LIST_W-1:0];
                CFG_LIMITED_LIST: r_lim_list <= i_cfg_wdata[LIST_W-1:0];
                CFG_RESERVE:      r_reserve  <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LISTS; i++) begin
                r_head[i]  <= (i == 0) ? '0 : LINK_NULL;
                r_count[i] <= (i == 0) ? FULL_CNT : '0;
            end
        end else if (r_state == ST_LINK) begin
            for (int i = 0; i < LISTS; i++) begin
                if (LIST_W'(i) == r_dst) begin
                    r_head[i]  <= r_e;
                    r_count[i] <= r_count[i] + COUNT_W'(1);
                end else if (LIST_W'(i) == r_src) begin
                    if (r_p >= ENTRY_LIM) begin
                        r_head[i] <= r_n;
                    end
                    r_count[i] <= r_count[i] - COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok    <= 1'b0;
            r_moved <= 1'b0;
        end else if (r_state == ST_IDLE && i_in_valid) begin
            r_ok    <= in_go;
            r_moved <= 1'b0;
        end else if (r_state == ST_READ) begin
            r_moved <= !same_list;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_e   <= in_e;
            r_dst <= in_dst;
        end
        if (r_state == ST_READ) begin
            r_src <= ow_rdata;
            r_p   <= pv_rdata;
            r_n   <= nx_rdata;
            r_h   <= dst_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.ok            <= r_ok;
            r_out.granted_entry <= r_ok ? r_e[ENTRY_W-1:0] : '0;
            r_out.list_size     <= r_ok ? dst_cnt : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### src/mlep_chk.sv
// Port checker for the multi-list entry pool and its bind to the top level.
// Depends on mlep_pkg.
module mlep_chk
    import mlep_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic [1:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(i_in_valid && o_in_ready)
                                   - 2'(o_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.ok |->
            o_out_item.granted_entry == '0 && o_out_item.list_size == '0)
        else $error("refused result carries data");

    a_grant_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.ok |-> o_out_item.list_size != '0)
        else $error("granted result reports an empty list");

    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("more than two items in flight");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind multi_list_entry_pool_core mlep_chk u_mlep_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
